// ===== rtl/pdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdrc_pkg
// Shared types and constants for the peer download rate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdrc_pkg;

    // Default values of the top-level parameters.
    localparam int OFFSET_BITS_DEF = 48;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed field widths of the stream payloads.
    localparam int REQ_W        = 3;
    localparam int NOW_W        = 32;
    localparam int OFF_W        = 48;
    localparam int BYTES_W      = 32;
    localparam int RATE_W       = 32;
    localparam int Q_W          = 16;
    localparam int IN_TDATA_W   = 120;
    localparam int OUT_TDATA_W  = 152;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_START      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK       = 2'd3;

    // Register reset values.
    localparam logic [7:0]  REQUEST_TIMEOUT_RST = 8'd5;
    localparam logic [7:0]  RECEIVE_TIMEOUT_RST = 8'd10;
    localparam logic [31:0] FAST_START_RST      = 32'd25600;
    localparam logic [15:0] MIN_CHUNK_RST       = 16'd128;

    // Event codes.
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RECEIVE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CONNECT    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DISCONNECT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GRANT      = 3'd4;

    // Rate change in signed Q2.14.
    localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;
    localparam logic signed [Q_W-1:0] Q_MIN = -16'sd1638;
    localparam int RTT_TARGET = 9;

    typedef enum logic [1:0] {
        LINK_OFFLINE     = 2'd0,
        LINK_IDLE        = 2'd1,
        LINK_DOWNLOADING = 2'd2
    } link_state_t;

    // One result item.
    typedef struct packed {
        logic [RATE_W-1:0]  rate_now;
        link_state_t        source_state;
        logic               invalidate_pending;
        logic               file_done;
        logic [BYTES_W-1:0] send_bytes;
        logic [OFF_W-1:0]   send_offset;
        logic               send_request;
        logic [BYTES_W-1:0] desired_bytes;
        logic               ask_alloc;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/pdrc_size_calc.sv =====
// ----------------------------------------------------------------------------
// pdrc_size_calc
// Request size for a tick: fast-start size, or the averaged rate scaled by
// the Q2.14 rate change, saturated to 32 bits and raised to the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrc_size_calc (
    input  wire logic [pdrc_pkg::RATE_W-1:0]       rate,
    input  wire logic signed [pdrc_pkg::Q_W-1:0]   rate_change,
    input  wire logic                              fast_start,
    input  wire logic [31:0]                       fast_start_bytes,
    input  wire logic [15:0]                       min_chunk_bytes,
    output logic [pdrc_pkg::BYTES_W-1:0]           size
);

    logic signed [16:0] factor_wide;
    logic [15:0]        factor;
    logic [47:0]        product;
    logic [33:0]        scaled;
    logic [31:0]        scaled_sat;
    logic [31:0]        raw_size;

    // The factor 1 + change stays within 14746..32768, so 16 unsigned bits hold it.
    assign factor_wide = 17'sd16384 + 17'(rate_change);
    assign factor      = factor_wide[15:0];
    assign product     = 48'(rate) * 48'(factor);
    assign scaled      = product[47:14];
    assign scaled_sat  = (scaled[33:32] != 2'b00) ? 32'hFFFF_FFFF : scaled[31:0];

    // Pick the size and apply the floor.
    assign raw_size = fast_start ? fast_start_bytes : scaled_sat;
    assign size     = (raw_size < 32'(min_chunk_bytes)) ? 32'(min_chunk_bytes) : raw_size;

endmodule

`default_nettype wire

// ===== rtl/peer_download_rate_controller.sv =====
// ----------------------------------------------------------------------------
// peer_download_rate_controller
// Request-size controller for one download source.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle while its results are being taken,
// and returns exactly one result for each one: the event is captured in
// an input register, all of its work (timeouts, rate averaging, the one 32x16
// multiply for the request size, RTT window handling) is done in a single
// combinational pass from that register, and the result lands in an output
// register. While a result waits to be taken, the input register still
// accepts one more event; after that the slave side stalls until the result
// is taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_download_rate_controller #(
    parameter int OFFSET_BITS = pdrc_pkg::OFFSET_BITS_DEF,
    parameter int TIME_BITS   = pdrc_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_we,
    input  wire logic [pdrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pdrc_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // now_s[31:0], chunk_offset[79:32], chunk_bytes[111:80], grant_ok[112], zero fill
    input  wire logic [pdrc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type[2:0]
    input  wire logic [pdrc_pkg::REQ_W-1:0]           s_axis_tuser,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // ask_alloc[0], desired_bytes[32:1], send_request[33], send_offset[81:34],
    // send_bytes[113:82], file_done[114], invalidate_pending[115],
    // source_state[117:116], rate_now[149:118], zero fill
    output logic [pdrc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;

    // Configuration registers.
    logic [7:0]  request_timeout_reg;
    logic [7:0]  receive_timeout_reg;
    logic [31:0] fast_start_reg;
    logic [15:0] min_chunk_reg;

    // Input register.
    logic                          in_valid_reg;
    logic [pdrc_pkg::REQ_W-1:0]    type_reg;
    logic [pdrc_pkg::NOW_W-1:0]    now_reg;
    logic [pdrc_pkg::OFF_W-1:0]    off_reg;
    logic [pdrc_pkg::BYTES_W-1:0]  bytes_reg;
    logic                          ok_reg;

    // Output register.
    logic                          out_valid_reg;
    pdrc_pkg::result_t             result_reg;
    pdrc_pkg::result_t             result_next;

    // Controller state.
    pdrc_pkg::link_state_t         link_reg, link_next;
    logic [TIME_BITS-1:0]          last_receive_reg, last_receive_next;
    logic [TIME_BITS-1:0]          last_request_reg, last_request_next;
    logic [7:0]                    retry_reg, retry_next;
    logic [31:0]                   avg_rate_reg, avg_rate_next;
    logic [31:0]                   tick_bytes_reg, tick_bytes_next;
    logic                          window_active_reg, window_active_next;
    logic [TIME_BITS-1:0]          window_start_reg, window_start_next;
    logic [OFFSET_BITS-1:0]        window_end_reg, window_end_next;
    logic signed [pdrc_pkg::Q_W-1:0] rate_change_reg, rate_change_next;
    logic                          fast_pending_reg, fast_pending_next;

    // Handshake.
    logic in_accept;
    logic advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Working values derived from the held event.
    logic [TIME_BITS-1:0]    now_t;
    logic [OFFSET_BITS-1:0]  off_t;
    logic [OFFSET_BITS-1:0]  end_offset;
    logic [TIME_BITS-1:0]    age_rcv;
    logic [TIME_BITS-1:0]    age_req;
    logic [TIME_BITS-1:0]    age_win;
    logic [8:0]              retry_inc;
    logic [16:0]             req_limit;
    logic                    req_expired;
    logic                    rcv_expired;
    logic                    win_late;
    logic [32:0]             avg_sum;
    logic [31:0]             avg_tick;
    logic [32:0]             tick_sum;
    logic signed [pdrc_pkg::Q_W-1:0] rate_change_tick;
    logic [3:0]              rtt_gap;
    logic signed [pdrc_pkg::Q_W-1:0] rate_change_rtt;
    logic [31:0]             tick_size;

    assign now_t      = TIME_BITS'(now_reg);
    assign off_t      = OFFSET_BITS'(off_reg);
    assign end_offset = OFFSET_BITS'(off_t + OFFSET_BITS'(bytes_reg));
    assign age_rcv    = TIME_BITS'(now_t - last_receive_reg);
    assign age_req    = TIME_BITS'(now_t - last_request_reg);
    assign age_win    = TIME_BITS'(now_t - window_start_reg);

    // Request timeout grows with the retry count.
    assign retry_inc   = 9'(retry_reg) + 9'd1;
    assign req_limit   = 17'(request_timeout_reg) * 17'(retry_inc);
    assign req_expired = CMP_W'(age_req) > CMP_W'(req_limit);
    // A request timeout refreshes the receive time, so the receive age is zero then.
    assign rcv_expired = !req_expired && (age_rcv > TIME_BITS'(receive_timeout_reg));
    assign win_late    = age_win > TIME_BITS'(pdrc_pkg::RTT_TARGET);

    // Rate average and saturating byte count.
    assign avg_sum  = 33'(avg_rate_reg) + 33'(tick_bytes_reg);
    assign avg_tick = avg_sum[32:1];
    assign tick_sum = 33'(tick_bytes_reg) + 33'(bytes_reg);

    // An open window that has run past the target drops any positive change.
    assign rate_change_tick = (window_active_reg && win_late && (rate_change_reg > 0))
                              ? '0 : rate_change_reg;

    // Rate change from a closed window, valid for round trips of 2 to 9 s.
    assign rtt_gap         = 4'(4'd9 - age_win[3:0]);
    assign rate_change_rtt = $signed({1'b0, rtt_gap, 11'b0});

    pdrc_size_calc u_size_calc (
        .rate             (avg_tick),
        .rate_change      (rate_change_tick),
        .fast_start       (fast_pending_reg),
        .fast_start_bytes (fast_start_reg),
        .min_chunk_bytes  (min_chunk_reg),
        .size             (tick_size)
    );

    // Event processing: next state and result.
    always_comb
    begin
        link_next          = link_reg;
        last_receive_next  = last_receive_reg;
        last_request_next  = last_request_reg;
        retry_next         = retry_reg;
        avg_rate_next      = avg_rate_reg;
        tick_bytes_next    = tick_bytes_reg;
        window_active_next = window_active_reg;
        window_start_next  = window_start_reg;
        window_end_next    = window_end_reg;
        rate_change_next   = rate_change_reg;
        fast_pending_next  = fast_pending_reg;
        result_next        = '0;

        case (type_reg)
            pdrc_pkg::REQ_TICK:
            begin
                if (link_reg != pdrc_pkg::LINK_OFFLINE)
                begin
                    if (req_expired)
                    begin
                        if (retry_reg != 8'hFF)
                        begin
                            retry_next = 8'(retry_reg + 8'd1);
                        end
                        link_next         = pdrc_pkg::LINK_DOWNLOADING;
                        last_receive_next = now_t;
                    end
                    if (rcv_expired)
                    begin
                        link_next = pdrc_pkg::LINK_IDLE;
                    end
                    else
                    begin
                        avg_rate_next             = avg_tick;
                        tick_bytes_next           = '0;
                        rate_change_next          = rate_change_tick;
                        fast_pending_next         = 1'b0;
                        last_request_next         = now_t;
                        result_next.ask_alloc     = 1'b1;
                        result_next.desired_bytes = tick_size;
                    end
                end
            end
            pdrc_pkg::REQ_RECEIVE:
            begin
                last_receive_next = now_t;
                retry_next        = '0;
                link_next         = pdrc_pkg::LINK_DOWNLOADING;
                tick_bytes_next   = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                if (window_active_reg && (window_end_reg == end_offset))
                begin
                    if (age_win <= TIME_BITS'(1))
                    begin
                        rate_change_next = pdrc_pkg::Q_ONE;
                    end
                    else if (!win_late)
                    begin
                        rate_change_next = rate_change_rtt;
                    end
                    else
                    begin
                        rate_change_next = pdrc_pkg::Q_MIN;
                    end
                    window_active_next = 1'b0;
                end
            end
            pdrc_pkg::REQ_CONNECT:
            begin
                link_next = pdrc_pkg::LINK_IDLE;
            end
            pdrc_pkg::REQ_DISCONNECT:
            begin
                link_next                      = pdrc_pkg::LINK_OFFLINE;
                fast_pending_next              = 1'b1;
                result_next.invalidate_pending = 1'b1;
            end
            pdrc_pkg::REQ_GRANT:
            begin
                if (!ok_reg)
                begin
                    result_next.file_done = 1'b1;
                end
                else if (bytes_reg != '0)
                begin
                    link_next                = pdrc_pkg::LINK_DOWNLOADING;
                    result_next.send_request = 1'b1;
                    result_next.send_offset  = pdrc_pkg::OFF_W'(off_t);
                    result_next.send_bytes   = bytes_reg;
                    if (!window_active_reg)
                    begin
                        window_start_next  = now_t;
                        window_active_next = 1'b1;
                        window_end_next    = end_offset;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result_next.source_state = link_next;
        result_next.rate_now     = avg_rate_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_timeout_reg <= pdrc_pkg::REQUEST_TIMEOUT_RST;
            receive_timeout_reg <= pdrc_pkg::RECEIVE_TIMEOUT_RST;
            fast_start_reg      <= pdrc_pkg::FAST_START_RST;
            min_chunk_reg       <= pdrc_pkg::MIN_CHUNK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdrc_pkg::CFG_REQUEST_TIMEOUT: request_timeout_reg <= cfg_data[7:0];
                pdrc_pkg::CFG_RECEIVE_TIMEOUT: receive_timeout_reg <= cfg_data[7:0];
                pdrc_pkg::CFG_FAST_START:      fast_start_reg      <= cfg_data[31:0];
                pdrc_pkg::CFG_MIN_CHUNK:       min_chunk_reg       <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Valid flags of the input and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg  <= s_axis_tuser;
            now_reg   <= s_axis_tdata[31:0];
            off_reg   <= s_axis_tdata[79:32];
            bytes_reg <= s_axis_tdata[111:80];
            ok_reg    <= s_axis_tdata[112];
        end
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Controller state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg          <= pdrc_pkg::LINK_OFFLINE;
            last_receive_reg  <= '0;
            last_request_reg  <= '0;
            retry_reg         <= '0;
            avg_rate_reg      <= '0;
            tick_bytes_reg    <= '0;
            window_active_reg <= 1'b0;
            window_start_reg  <= '0;
            window_end_reg    <= '0;
            rate_change_reg   <= '0;
            fast_pending_reg  <= 1'b1;
        end
        else if (advance)
        begin
            link_reg          <= link_next;
            last_receive_reg  <= last_receive_next;
            last_request_reg  <= last_request_next;
            retry_reg         <= retry_next;
            avg_rate_reg      <= avg_rate_next;
            tick_bytes_reg    <= tick_bytes_next;
            window_active_reg <= window_active_next;
            window_start_reg  <= window_start_next;
            window_end_reg    <= window_end_next;
            rate_change_reg   <= rate_change_next;
            fast_pending_reg  <= fast_pending_next;
        end
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg};

    // A result carries at most one action.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0({result_reg.ask_alloc, result_reg.send_request,
                                    result_reg.file_done, result_reg.invalidate_pending}))
        else $error("result carries more than one action");

    // A requested size never falls below the configured minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.ask_alloc) |->
            (result_reg.desired_bytes >= 32'(min_chunk_reg)))
        else $error("desired size below minimum chunk");

    // A disconnect leaves the source offline with fast start armed again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (type_reg == pdrc_pkg::REQ_DISCONNECT)) |=>
            ((link_reg == pdrc_pkg::LINK_OFFLINE) && fast_pending_reg))
        else $error("disconnect did not reset link state");

    // An offline tick changes neither the rate nor the request time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (type_reg == pdrc_pkg::REQ_TICK) &&
         (link_reg == pdrc_pkg::LINK_OFFLINE)) |=>
            ($stable(avg_rate_reg) && $stable(last_request_reg) && !result_reg.ask_alloc))
        else $error("offline tick changed state");

endmodule

`default_nettype wire
